/* rtl/core/drbg_pkg.sv */
// package for the ctr_drbg aes-256 core: types, constants, aes helper functions
// no dependencies
`default_nettype none
package drbg_pkg;

   localparam int MaxReqBytes = 1024;
   localparam int ReqBytesW   = 11;
   localparam int ReqDataW    = 512;
   localparam int RspDataW    = 136;

   typedef enum logic [0:0] {
      REQ_INSTANTIATE = 1'b0,
      REQ_GENERATE    = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEXP_START,
      ST_KEXP,
      ST_INST_KEXP,
      ST_GEN_START,
      ST_GEN_RUN,
      ST_GEN_OUT,
      ST_EMPTY_OUT,
      ST_UPD_START,
      ST_UPD_RUN,
      ST_UPD_FINISH
   } state_type;

   typedef struct packed {
      logic clear_state;
      logic load_seed;
      logic clear_seed;
      logic kexp_start;
      logic enc_start;
      logic gen_capture;
      logic upd_capture;
      logic upd_commit;
      logic load_count;
      logic out_load;
      logic out_empty;
   } cmd_type;

   typedef struct packed {
      logic kexp_done;
      logic enc_done;
      logic count_zero;
      logic last_block;
      logic upd_last;
      logic out_full;
   } status_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

endpackage
`default_nettype wire

/* rtl/core/drbg_aes_round.sv */
// one aes-256 encryption round per cycle, round keys read from key store
// depends on drbg_pkg
`default_nettype none
module drbg_aes_round (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] block_in,
   input  wire logic [127:0] rkey,
   output logic [3:0]        rkey_sel,
   output logic              done,
   output logic [127:0]      block_out
);
   import drbg_pkg::*;

   logic [127:0] st_ff, st_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [7:0]   sb [16];
   logic [7:0]   mc [16];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sb[c*4+i] = sbox(st_ff[127 - 8*(((c+i)%4)*4+i) -: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            mc[c*4+i] = sb[c*4+i] ^ sb[c*4] ^ sb[c*4+1] ^ sb[c*4+2] ^ sb[c*4+3]
                        ^ xtime(sb[c*4+i] ^ sb[c*4+((i+1)%4)]);
         end
      end
   end

   always_comb begin
      st_in   = st_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rkey_sel = start ? 4'd0 : rnd_ff;
      if (start) begin
         st_in   = block_in ^ rkey;
         rnd_in  = 4'd1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int k = 0; k < 16; k++) begin
            st_in[127 - 8*k -: 8] = ((rnd_ff == 4'd14) ? sb[k] : mc[k])
                                    ^ rkey[127 - 8*k -: 8];
         end
         rnd_in = rnd_ff + 4'd1;
         if (rnd_ff == 4'd14) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
      end
      st_ff <= st_in;
   end

   assign done      = done_ff;
   assign block_out = st_ff;
endmodule
`default_nettype wire

/* rtl/core/drbg_datapath.sv */
// datapath: key, counter, key schedule, aes round unit, update buffer, output register
// depends on drbg_pkg, drbg_aes_round
`default_nettype none
module drbg_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire drbg_pkg::cmd_type         cmd,
   output drbg_pkg::status_type           status,
   input  wire logic [383:0]              seed,
   input  wire logic [drbg_pkg::ReqBytesW-1:0] req_bytes,
   input  wire logic                      out_take,
   output logic [127:0]                   out_block,
   output logic [4:0]                     out_valid_bytes,
   output logic                           out_last
);
   import drbg_pkg::*;

   logic [255:0] key_ff, key_in;
   logic [127:0] ctr_ff, ctr_in;
   logic [383:0] seed_ff, seed_in;
   logic [383:0] tbuf_ff, tbuf_in;
   logic [1:0]   ucnt_ff, ucnt_in;
   logic [ReqBytesW-1:0] rem_ff, rem_in;
   logic [127:0] rk_ff [15];
   logic [127:0] rk_in [15];
   logic [5:0]   kidx_ff, kidx_in;
   logic [5:0]   kprev;
   logic [5:0]   kback;
   logic         kbusy_ff, kbusy_in;
   logic         kdone_ff, kdone_in;
   logic [127:0] ob_ff, ob_in;
   logic [4:0]   ovb_ff, ovb_in;
   logic         olast_ff, olast_in;
   logic         ofull_ff, ofull_in;
   logic [3:0]   rsel;
   logic [127:0] rkey;
   logic         enc_done;
   logic [127:0] enc_out;
   logic [127:0] ctr_inc;
   logic [4:0]   take;
   logic [127:0] mask;
   logic [31:0]  tw;

   assign ctr_inc = ctr_ff + 128'd1;
   assign kprev   = kidx_ff - 6'd1;
   assign kback   = kidx_ff - 6'd8;
   assign rkey    = rk_ff[rsel];

   drbg_aes_round u_round (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.enc_start),
      .block_in  (ctr_inc),
      .rkey      (rkey),
      .rkey_sel  (rsel),
      .done      (enc_done),
      .block_out (enc_out)
   );

   always_comb begin
      take = (rem_ff >= ReqBytesW'(16)) ? 5'd16 : rem_ff[4:0];
      mask = '1;
      for (int k = 0; k < 16; k++) begin
         if (5'(k) >= take) mask[127 - 8*k -: 8] = 8'h00;
      end
      tw = rk_ff[kprev[5:2]][127 - 32*kprev[1:0] -: 32];
      if (kidx_ff[2:0] == 3'd0) begin
         tw = sub_word({tw[23:0], tw[31:24]}) ^ {8'(8'h01 << (kidx_ff[5:3] - 3'd1)), 24'h0};
      end else if (kidx_ff[2:0] == 3'd4) begin
         tw = sub_word(tw);
      end
   end

   always_comb begin
      key_in   = key_ff;
      ctr_in   = ctr_ff;
      seed_in  = seed_ff;
      tbuf_in  = tbuf_ff;
      ucnt_in  = ucnt_ff;
      rem_in   = rem_ff;
      rk_in    = rk_ff;
      kidx_in  = kidx_ff;
      kbusy_in = kbusy_ff;
      kdone_in = 1'b0;
      ob_in    = ob_ff;
      ovb_in   = ovb_ff;
      olast_in = olast_ff;
      ofull_in = ofull_ff && !out_take;
      if (cmd.clear_state) begin
         key_in = '0;
         ctr_in = '0;
      end
      if (cmd.load_seed) seed_in = seed;
      if (cmd.clear_seed) seed_in = '0;
      if (cmd.load_count) begin
         rem_in = (req_bytes > ReqBytesW'(MaxReqBytes)) ? ReqBytesW'(MaxReqBytes) : req_bytes;
         ucnt_in = 2'd0;
      end
      if (cmd.enc_start) ctr_in = ctr_inc;
      if (cmd.upd_capture) begin
         tbuf_in = {tbuf_ff[255:0], enc_out};
         ucnt_in = ucnt_ff + 2'd1;
      end
      if (cmd.upd_commit) begin
         key_in = tbuf_ff[383:128] ^ seed_ff[383:128];
         ctr_in = tbuf_ff[127:0] ^ seed_ff[127:0];
      end
      // schedule starts from the key written in the same cycle
      if (cmd.kexp_start) begin
         rk_in[0] = key_in[255:128];
         rk_in[1] = key_in[127:0];
         kidx_in  = 6'd8;
         kbusy_in = 1'b1;
      end else if (kbusy_ff) begin
         rk_in[kidx_ff[5:2]][127 - 32*kidx_ff[1:0] -: 32] =
            rk_ff[kback[5:2]][127 - 32*kback[1:0] -: 32] ^ tw;
         kidx_in = kidx_ff + 6'd1;
         if (kidx_ff == 6'd59) begin
            kbusy_in = 1'b0;
            kdone_in = 1'b1;
         end
      end
      if (cmd.gen_capture) begin
         ob_in    = enc_out & mask;
         ovb_in   = take;
         olast_in = (rem_ff == ReqBytesW'(take));
         rem_in   = rem_ff - ReqBytesW'(take);
      end
      if (cmd.out_empty) begin
         ob_in    = '0;
         ovb_in   = 5'd0;
         olast_in = 1'b1;
      end
      if (cmd.out_load) ofull_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         ctr_ff   <= '0;
         kbusy_ff <= 1'b0;
         kdone_ff <= 1'b0;
         ofull_ff <= 1'b0;
         kidx_ff  <= 6'd0;
      end else begin
         key_ff   <= key_in;
         ctr_ff   <= ctr_in;
         kbusy_ff <= kbusy_in;
         kdone_ff <= kdone_in;
         ofull_ff <= ofull_in;
         kidx_ff  <= kidx_in;
      end
      seed_ff  <= seed_in;
      tbuf_ff  <= tbuf_in;
      ucnt_ff  <= ucnt_in;
      rem_ff   <= rem_in;
      rk_ff    <= rk_in;
      ob_ff    <= ob_in;
      ovb_ff   <= ovb_in;
      olast_ff <= olast_in;
   end

   always_comb begin
      status.kexp_done  = kdone_ff;
      status.enc_done   = enc_done;
      status.count_zero = (rem_ff == '0);
      status.last_block = (rem_ff <= ReqBytesW'(16));
      status.upd_last   = (ucnt_ff == 2'd2);
      status.out_full   = ofull_ff;
   end

   assign out_block       = ob_ff;
   assign out_valid_bytes = ovb_ff;
   assign out_last        = olast_ff;
endmodule
`default_nettype wire

/* rtl/core/drbg_ctrl.sv */
// controller state machine sequencing instantiate, generate and update
// depends on drbg_pkg
`default_nettype none
module drbg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   output logic                      req_ready,
   input  wire drbg_pkg::status_type status,
   output drbg_pkg::cmd_type         cmd
);
   import drbg_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_KEXP_START;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !status.out_full;
            if (req_valid && !status.out_full) begin
               cmd.load_count = 1'b1;
               if (req_kind == REQ_INSTANTIATE) begin
                  cmd.clear_state = 1'b1;
                  cmd.load_seed   = 1'b1;
                  cmd.kexp_start  = 1'b1;
                  state_in        = ST_INST_KEXP;
               end else begin
                  cmd.clear_seed = 1'b1;
                  state_in       = ST_GEN_START;
               end
            end
         end
         ST_KEXP_START: begin
            cmd.kexp_start = 1'b1;
            state_in       = ST_KEXP;
         end
         ST_KEXP: begin
            if (status.kexp_done) state_in = ST_IDLE;
         end
         ST_INST_KEXP: begin
            if (status.kexp_done) state_in = ST_UPD_START;
         end
         ST_GEN_START: begin
            if (status.count_zero) begin
               state_in = ST_EMPTY_OUT;
            end else begin
               cmd.enc_start = 1'b1;
               state_in      = ST_GEN_RUN;
            end
         end
         ST_GEN_RUN: begin
            if (status.enc_done) state_in = ST_GEN_OUT;
         end
         ST_GEN_OUT: begin
            if (!status.out_full) begin
               cmd.gen_capture = 1'b1;
               cmd.out_load    = 1'b1;
               if (status.last_block) state_in = ST_UPD_START;
               else                   state_in = ST_GEN_START;
            end
         end
         ST_EMPTY_OUT: begin
            if (!status.out_full) begin
               cmd.out_empty = 1'b1;
               cmd.out_load  = 1'b1;
               state_in      = ST_UPD_START;
            end
         end
         ST_UPD_START: begin
            cmd.enc_start = 1'b1;
            state_in      = ST_UPD_RUN;
         end
         ST_UPD_RUN: begin
            if (status.enc_done) begin
               cmd.upd_capture = 1'b1;
               if (status.upd_last) state_in = ST_UPD_FINISH;
               else                 state_in = ST_UPD_START;
            end
         end
         ST_UPD_FINISH: begin
            cmd.upd_commit = 1'b1;
            cmd.kexp_start = 1'b1;
            state_in       = ST_KEXP;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* rtl/core/ctr_drbg_aes256_core.sv */
// instantiate: key schedule of the zero key, three aes runs, commit, then a key schedule
// of the new key before ready
// generate: blocks from the one shared aes round unit, then an update
// output stalls hold generation; one request at a time
// reset: synchronous; key and counter cleared, then a key schedule before ready
// depends on drbg_pkg, drbg_ctrl, drbg_datapath
`default_nettype none
module ctr_drbg_aes256_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [399:0] req_tdata,   // seed_w0..seed_w5, req_bytes, zero fill
   input  wire logic         req_tuser,   // req_type
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,   // block_hi, block_lo, valid_bytes, zero fill
   output logic              rsp_tlast    // last
);
   import drbg_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [127:0] blk;
   logic [4:0]   vb;

   drbg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   drbg_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .seed            ({req_tdata[63:0], req_tdata[127:64], req_tdata[191:128],
                         req_tdata[255:192], req_tdata[319:256], req_tdata[383:320]}),
      .req_bytes       (req_tdata[394:384]),
      .out_take        (rsp_tready),
      .out_block       (blk),
      .out_valid_bytes (vb),
      .out_last        (rsp_tlast)
   );

   assign rsp_tvalid = status.out_full;
   assign rsp_tdata  = {3'b000, vb, blk[63:0], blk[127:64]};
endmodule
`default_nettype wire

/* tb/ctr_drbg_aes256_core_tb.sv */
// testbench for ctr_drbg_aes256_core: directed and random instantiate/generate transfers,
// checked against an in-bench aes-256 ctr_drbg predictor through a small scoreboard class
// depends on drbg_pkg and the core rtl
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
   logic [63:0] hi;
   logic [63:0] lo;
   logic [4:0]  nbytes;
   logic        last;
} drbg_block_type;

class drbg_scoreboard;
   logic [7:0]   sb [256];
   logic [63:0]  key [4];
   logic [63:0]  ctr_hi, ctr_lo;
   logic [7:0]   rk [240];
   drbg_block_type pending [$];
   int           errors;

   function new();
      sb = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      errors = 0;
      clear_state();
   endfunction

   function void clear_state();
      foreach (key[i]) key[i] = '0;
      ctr_hi = '0;
      ctr_lo = '0;
      schedule_keys();
   endfunction

   function void schedule_keys();
      logic [7:0] t [4];
      logic [7:0] s;
      logic [7:0] rc;
      for (int i = 0; i < 32; i++) rk[i] = key[i / 8][63 - 8 * (i % 8) -: 8];
      rc = 8'h01;
      for (int i = 8; i < 60; i++) begin
         for (int j = 0; j < 4; j++) t[j] = rk[4 * (i - 1) + j];
         if (i % 8 == 0) begin
            s = t[0];
            t[0] = sb[t[1]] ^ rc;
            t[1] = sb[t[2]];
            t[2] = sb[t[3]];
            t[3] = sb[s];
            rc = rc << 1;
         end else if (i % 8 == 4) begin
            for (int j = 0; j < 4; j++) t[j] = sb[t[j]];
         end
         for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 8) + j] ^ t[j];
      end
   endfunction

   function logic [7:0] dbl(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function logic [127:0] cipher(logic [127:0] pt);
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] ct;
      for (int i = 0; i < 16; i++) st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
      for (int r = 1; r <= 14; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) tmp[c * 4 + i] = sb[st[((c + i) % 4) * 4 + i]];
         if (r != 14) begin
            for (int c = 0; c < 4; c++) begin
               a0 = tmp[c * 4]; a1 = tmp[c * 4 + 1]; a2 = tmp[c * 4 + 2]; a3 = tmp[c * 4 + 3];
               all = a0 ^ a1 ^ a2 ^ a3;
               tmp[c * 4]     = a0 ^ all ^ dbl(a0 ^ a1);
               tmp[c * 4 + 1] = a1 ^ all ^ dbl(a1 ^ a2);
               tmp[c * 4 + 2] = a2 ^ all ^ dbl(a2 ^ a3);
               tmp[c * 4 + 3] = a3 ^ all ^ dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16 * r + i];
      end
      for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = st[i];
      return ct;
   endfunction

   function logic [127:0] step_keystream();
      {ctr_hi, ctr_lo} = {ctr_hi, ctr_lo} + 128'd1;
      return cipher({ctr_hi, ctr_lo});
   endfunction

   function void reseed(logic [383:0] data);
      logic [383:0] t;
      for (int i = 0; i < 3; i++) t[383 - 128 * i -: 128] = step_keystream();
      t ^= data;
      for (int i = 0; i < 4; i++) key[i] = t[383 - 64 * i -: 64];
      ctr_hi = t[127:64];
      ctr_lo = t[63:0];
      schedule_keys();
   endfunction

   // note one accepted request and queue the blocks it should produce
   function void note_request(drbg_pkg::req_kind_type kind, logic [383:0] seed,
                              logic [10:0] nreq);
      int n, take;
      logic [127:0] blk;
      drbg_block_type b;
      if (kind == drbg_pkg::REQ_INSTANTIATE) begin
         clear_state();
         reseed(seed);
         return;
      end
      n = (nreq > drbg_pkg::MaxReqBytes) ? drbg_pkg::MaxReqBytes : nreq;
      if (n == 0) begin
         b.hi = '0; b.lo = '0; b.nbytes = '0; b.last = 1'b1;
         pending.push_back(b);
      end
      while (n > 0) begin
         take = (n >= 16) ? 16 : n;
         blk = step_keystream();
         for (int i = take; i < 16; i++) blk[127 - 8 * i -: 8] = 8'h00;
         n -= take;
         b.hi = blk[127:64]; b.lo = blk[63:0]; b.nbytes = take[4:0]; b.last = (n == 0);
         pending.push_back(b);
      end
      reseed('0);
   endfunction

   function void check_block(logic [135:0] data, logic last);
      drbg_block_type e;
      if (pending.size() == 0) begin
         $display("%0t unexpected block: got %h last %b", $time, data, last);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (data[63:0] !== e.hi || data[127:64] !== e.lo || data[132:128] !== e.nbytes
          || data[135:133] !== 3'b0 || last !== e.last) begin
         $display("%0t block mismatch: expected hi %h lo %h n %0d last %b", $time,
                  e.hi, e.lo, e.nbytes, e.last);
         $display("%0t                 actual   hi %h lo %h n %0d last %b", $time,
                  data[63:0], data[127:64], data[132:128], last);
         errors++;
      end
   endfunction
endclass

module ctr_drbg_aes256_core_tb;
   import drbg_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [399:0] req_tdata;   // seed_w0..seed_w5, req_bytes, zero fill
   logic         req_tuser;   // req_type
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;   // block_hi, block_lo, valid_bytes, zero fill
   logic         rsp_tlast;   // last

   drbg_scoreboard board;
   bit             stimulus_done;
   int             hold_off;

   ctr_drbg_aes256_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [10:0] rand_count();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 11'($urandom_range(1000, 2047));
      if (pick < 3) return 11'($urandom_range(0, 1024));
      return 11'($urandom_range(0, 64));
   endfunction

   // seed[383:320] is seed_w0, which travels in the lowest tdata bits
   task automatic send_request(req_kind_type kind, logic [383:0] seed, logic [10:0] nreq);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, nreq, seed[63:0], seed[127:64], seed[191:128], seed[255:192],
                     seed[319:256], seed[383:320]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, seed, nreq);
   endtask

   task automatic send_seed(logic [383:0] seed);
      send_request(REQ_INSTANTIATE, seed, 11'($urandom()));
   endtask

   task automatic send_generate(logic [10:0] nreq);
      send_request(REQ_GENERATE, {rand64(), rand64(), rand64(), rand64(), rand64(), rand64()},
                   nreq);
   endtask

   // receiver: random stalls, plus one long hold-off to back up the block
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_block(rsp_tdata, rsp_tlast);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         end
      end
   end

   initial begin
      board = new();
      stimulus_done = 1'b0;
      hold_off = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_generate(11'd16);
      send_generate(11'd0);
      send_seed('0);
      send_generate(11'd1);
      send_generate(11'd7);
      send_generate(11'd8);
      send_generate(11'd9);
      send_generate(11'd15);
      send_generate(11'd17);
      send_seed({384{1'b1}});
      send_generate(11'd1024);
      send_generate(11'd1025);
      send_generate(11'd2047);
      send_seed({rand64(), rand64(), rand64(), rand64(), rand64(), rand64()});
      send_generate(11'd0);
      send_generate(11'd33);
      hold_off = 400;
      for (int i = 0; i < 6; i++) send_generate(11'd48);

      // random part, mostly generates with occasional reseeds
      for (int i = 0; i < 380; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_seed({rand64(), rand64(), rand64(), rand64(), rand64(), rand64()});
         else
            send_generate(rand_count());
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #100ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

`default_nettype wire

/* sim.f */
rtl/core/drbg_pkg.sv
rtl/core/drbg_aes_round.sv
rtl/core/drbg_datapath.sv
rtl/core/drbg_ctrl.sv
rtl/core/ctr_drbg_aes256_core.sv
tb/ctr_drbg_aes256_core_tb.sv
